// ===== sv/srs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_pkg
// Shared sizes and controller/datapath interface types of the string sorter.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int MAX_STRINGS = 64;
  localparam int MAX_LEN     = 64;

  localparam int STR_W  = $clog2(MAX_STRINGS);   // string slot index
  localparam int LEN_W  = $clog2(MAX_LEN);       // byte offset in a slot
  localparam int CNT_W  = STR_W + 1;             // string count, 0..MAX_STRINGS
  localparam int POS_W  = LEN_W + 1;             // length, 0..MAX_LEN
  localparam int ADDR_W = STR_W + LEN_W;
  localparam int META_W = 2 * POS_W;             // {length, distinct count}

  localparam logic [CNT_W-1:0] MAX_STR_C = CNT_W'(MAX_STRINGS);
  localparam logic [POS_W-1:0] MAX_LEN_C = POS_W'(MAX_LEN);

  localparam logic [1:0] MODE_ASC      = 2'd0;
  localparam logic [1:0] MODE_DESC     = 2'd1;
  localparam logic [1:0] MODE_LENGTH   = 2'd2;
  localparam logic [1:0] MODE_DISTINCT = 2'd3;

  typedef struct packed {
    logic load;        // take one input beat into the string store
    logic start_sort;  // i, j and rank to zero
    logic j_inc;
    logic rank_inc;
    logic write_rank;  // sorted[rank] = i, then next i
    logic rd_meta;
    logic k_clr;
    logic rd_byte;
    logic k_inc;
    logic o_clr;
    logic rd_out;
    logic o_inc;
    logic clr_count;
  } srs_cmd_t;

  typedef struct packed {
    logic j_is_n;
    logic j_is_i;
    logic i_last;
    logic meta_decides;
    logic meta_before;
    logic k_end;
    logic byte_diff;
    logic byte_before;
    logic len_before;
    logic o_last;
  } srs_stat_t;

endpackage
`default_nettype wire

// ===== sv/srs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/srs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_datapath
// String store, per-string tables, pair comparison and the sorted order.
// ----------------------------------------------------------------------------
module srs_datapath
  import srs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire srs_cmd_t    cmd,
  output srs_stat_t        stat,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_mode,
  input  wire logic [7:0]  char_byte,
  input  wire logic        string_end,
  input  wire logic        set_end,
  output logic [STR_W-1:0] string_index
);

  logic [1:0]       mode;
  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] distinct;
  logic [255:0]     seen;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [STR_W-1:0] rank;
  logic [POS_W-1:0] k;
  logic [CNT_W-1:0] o;

  logic has_room, store, is_new, closing, meta_we;
  logic [POS_W-1:0] len_w, dist_w;
  logic [ADDR_W-1:0] wr_addr;
  logic [META_W-1:0] meta_j, meta_i;
  logic [POS_W-1:0] lj, li, dj, di, lmin;
  logic [7:0] bj, bi;

  assign has_room = count < MAX_STR_C;
  assign store    = cmd.load && has_room && (pos < MAX_LEN_C);
  assign is_new   = !seen[char_byte];
  assign closing  = string_end || set_end;
  assign meta_we  = cmd.load && has_room && closing;
  assign len_w    = store ? pos + POS_W'(1) : pos;
  assign dist_w   = (store && is_new) ? distinct + POS_W'(1) : distinct;
  assign wr_addr  = {count[STR_W-1:0], pos[LEN_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_ASC;
      count    <= '0;
      pos      <= '0;
      distinct <= '0;
      seen     <= '0;
      i        <= '0;
      j        <= '0;
      rank     <= '0;
      k        <= '0;
      o        <= '0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_mode;
      end
      if (cmd.load) begin
        if (closing) begin
          pos      <= '0;
          distinct <= '0;
          seen     <= '0;
        end else if (store) begin
          pos      <= len_w;
          distinct <= dist_w;
          seen[char_byte] <= 1'b1;
        end
        if (meta_we) begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.clr_count) begin
        count <= '0;
      end
      if (cmd.start_sort) begin
        i    <= '0;
        j    <= '0;
        rank <= '0;
      end
      if (cmd.j_inc) begin
        j <= j + CNT_W'(1);
      end
      if (cmd.rank_inc) begin
        rank <= rank + STR_W'(1);
      end
      if (cmd.write_rank) begin
        i    <= i + CNT_W'(1);
        j    <= '0;
        rank <= '0;
      end
      if (cmd.k_clr) begin
        k <= '0;
      end
      if (cmd.k_inc) begin
        k <= k + POS_W'(1);
      end
      if (cmd.o_clr) begin
        o <= '0;
      end
      if (cmd.o_inc) begin
        o <= o + CNT_W'(1);
      end
    end
  end

  // Two copies of the string store and of the per-string table so that strings j and i are read together.
  srs_ram #(.WIDTH(8), .DEPTH(MAX_STRINGS * MAX_LEN)) u_char_j (
    .clk(clk), .wr_en(store), .wr_addr(wr_addr), .wr_data(char_byte),
    .rd_en(cmd.rd_byte), .rd_addr({j[STR_W-1:0], k[LEN_W-1:0]}), .rd_data(bj)
  );
  srs_ram #(.WIDTH(8), .DEPTH(MAX_STRINGS * MAX_LEN)) u_char_i (
    .clk(clk), .wr_en(store), .wr_addr(wr_addr), .wr_data(char_byte),
    .rd_en(cmd.rd_byte), .rd_addr({i[STR_W-1:0], k[LEN_W-1:0]}), .rd_data(bi)
  );
  srs_ram #(.WIDTH(META_W), .DEPTH(MAX_STRINGS)) u_meta_j (
    .clk(clk), .wr_en(meta_we), .wr_addr(count[STR_W-1:0]), .wr_data({len_w, dist_w}),
    .rd_en(cmd.rd_meta), .rd_addr(j[STR_W-1:0]), .rd_data(meta_j)
  );
  srs_ram #(.WIDTH(META_W), .DEPTH(MAX_STRINGS)) u_meta_i (
    .clk(clk), .wr_en(meta_we), .wr_addr(count[STR_W-1:0]), .wr_data({len_w, dist_w}),
    .rd_en(cmd.rd_meta), .rd_addr(i[STR_W-1:0]), .rd_data(meta_i)
  );
  srs_ram #(.WIDTH(STR_W), .DEPTH(MAX_STRINGS)) u_sorted (
    .clk(clk), .wr_en(cmd.write_rank), .wr_addr(rank), .wr_data(i[STR_W-1:0]),
    .rd_en(cmd.rd_out), .rd_addr(o[STR_W-1:0]), .rd_data(string_index)
  );

  assign lj   = meta_j[META_W-1:POS_W];
  assign dj   = meta_j[POS_W-1:0];
  assign li   = meta_i[META_W-1:POS_W];
  assign di   = meta_i[POS_W-1:0];
  assign lmin = (lj < li) ? lj : li;

  always_comb begin
    stat.j_is_n       = (j == count);
    stat.j_is_i       = (j == i);
    stat.i_last       = (i + CNT_W'(1) == count);
    stat.o_last       = (o + CNT_W'(1) == count);
    stat.meta_decides = ((mode == MODE_LENGTH) && (lj != li))
                     || ((mode == MODE_DISTINCT) && (dj != di));
    stat.meta_before  = (mode == MODE_LENGTH) ? (lj < li) : (dj < di);
    stat.k_end        = (k == lmin);
    stat.byte_diff    = (bj != bi);
    // Descending order reverses both the byte and the prefix decisions.
    stat.byte_before  = (mode == MODE_DESC) ? (bj > bi) : (bj < bi);
    if (lj == li) begin
      stat.len_before = (j < i);
    end else begin
      stat.len_before = (mode == MODE_DESC) ? (lj > li) : (lj < li);
    end
  end

endmodule
`default_nettype wire

// ===== sv/srs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_ctrl
// Sequencer: load, pairwise ranking, and delivery of the sorted indices.
// ----------------------------------------------------------------------------
module srs_ctrl
  import srs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      set_end,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire srs_stat_t stat,
  output srs_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_LOAD, S_PAIR, S_META, S_BYTE_ISS, S_BYTE_CHK, S_OUT_RD, S_OUT_SHOW
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT_SHOW);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (set_end) begin
            cmd.start_sort = 1'b1;
            state_next     = S_PAIR;
          end
        end
      end
      S_PAIR: begin
        if (stat.j_is_n) begin
          cmd.write_rank = 1'b1;
          if (stat.i_last) begin
            cmd.o_clr  = 1'b1;
            state_next = S_OUT_RD;
          end
        end else if (stat.j_is_i) begin
          cmd.j_inc = 1'b1;
        end else begin
          cmd.rd_meta = 1'b1;
          state_next  = S_META;
        end
      end
      S_META: begin
        if (stat.meta_decides) begin
          cmd.rank_inc = stat.meta_before;
          cmd.j_inc    = 1'b1;
          state_next   = S_PAIR;
        end else begin
          cmd.k_clr  = 1'b1;
          state_next = S_BYTE_ISS;
        end
      end
      S_BYTE_ISS: begin
        if (stat.k_end) begin
          cmd.rank_inc = stat.len_before;
          cmd.j_inc    = 1'b1;
          state_next   = S_PAIR;
        end else begin
          cmd.rd_byte = 1'b1;
          state_next  = S_BYTE_CHK;
        end
      end
      S_BYTE_CHK: begin
        if (stat.byte_diff) begin
          cmd.rank_inc = stat.byte_before;
          cmd.j_inc    = 1'b1;
          state_next   = S_PAIR;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_BYTE_ISS;
        end
      end
      S_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = S_OUT_SHOW;
      end
      S_OUT_SHOW: begin
        if (out_ready) begin
          cmd.o_inc = 1'b1;
          if (stat.o_last) begin
            cmd.clr_count = 1'b1;
            state_next    = S_LOAD;
          end else begin
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/string_rank_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_rank_sorter
// Rank sort of a set of byte strings, emitting arrival indices in order.
// ----------------------------------------------------------------------------
// Bytes are taken one beat per cycle while loading. The beat carrying
// set_end closes the set; input then stalls while every string is ranked
// against every other one. Each ordered pair of different strings first
// fetches its lengths and distinct counts. When those do not decide the
// pair, the common prefix bytes are compared one pair at a time, each byte
// pair coming from a registered read of the two string store copies, until
// a byte differs or the shorter string runs out. A string's pairing with
// itself is skipped, and its rank is then recorded. The sorted indices then
// leave one beat at a time (sorted-order memory read, then output), and
// loading resumes after the last one. Bytes past 64 in a string and strings
// past 64 in a set are dropped.
module string_rank_sorter
  import srs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  sort_mode,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_byte,
  input  wire logic        string_end,
  input  wire logic        set_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       string_index,
  output logic             last_result
);

  srs_cmd_t  cmd;
  srs_stat_t stat;
  logic [STR_W-1:0] idx;

  assign cfg_ready    = 1'b1;
  assign string_index = 6'(idx);
  assign last_result  = stat.o_last;

  srs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .set_end(set_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  srs_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid), .cfg_mode(sort_mode),
    .char_byte(char_byte), .string_end(string_end), .set_end(set_end),
    .string_index(idx)
  );

endmodule
`default_nettype wire
